FILE: rtl/core/xcr_pkg.sv
// xcr_pkg: constants, codes and types shared by the xmodem checksum receiver
// no dependencies; imported by the interfaces and every module of the block
package xcr_pkg;

    localparam int DATA_BYTES  = 128;
    localparam int WORD_BYTES  = 8;
    localparam int NUM_WORDS   = DATA_BYTES / WORD_BYTES;
    localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
    localparam int LANE_W      = $clog2(WORD_BYTES);
    localparam int BYTE_IDX_W  = $clog2(DATA_BYTES);
    localparam int HDR_BYTES   = 2;
    localparam int FIRST_DATA  = HDR_BYTES + 1;
    localparam int LAST_COUNT  = DATA_BYTES + HDR_BYTES + 1;

    localparam logic [7:0]  CH_SOH = 8'h01;
    localparam logic [7:0]  CH_EOT = 8'h04;
    localparam logic [7:0]  CH_ACK = 8'h06;
    localparam logic [7:0]  CH_NAK = 8'h15;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [1:0] {
        FUNC_BYTE  = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_START = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_IDLE    = 2'd1,
        MODE_PACKET  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_RUN   = 2'd0,
        PH_READ  = 2'd1,
        PH_WRITE = 2'd2,
        PH_ACK   = 2'd3
    } phase_t;

    typedef enum logic {
        CFG_START_ADDR    = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic                  we;
        logic [WORD_IDX_W-1:0] widx;
        logic [LANE_W-1:0]     lane;
        logic [7:0]            wdata;
        logic                  re;
        logic [WORD_IDX_W-1:0] ridx;
    } store_req_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        wr_valid;
        logic [31:0] wr_addr;
        logic [63:0] wr_data;
        logic        done_res;
        logic        last;
    } res_t;

endpackage

FILE: rtl/core/xcr_cmd_if.sv
// xcr_cmd_if: input item channel (func, rx_byte) with valid/ready
// depends on xcr_pkg
interface xcr_cmd_if;
    import xcr_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

FILE: rtl/core/xcr_res_if.sv
// xcr_res_if: result item channel (reply byte, memory word write, done) with valid/ready
// depends on xcr_pkg
interface xcr_res_if;
    import xcr_pkg::*;

    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        wr_valid;
    logic [31:0] wr_addr;
    logic [63:0] wr_data;
    logic        done_res;
    logic        last;

    modport source (output valid, output tx_valid, output tx_byte, output wr_valid,
                    output wr_addr, output wr_data, output done_res, output last,
                    input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input wr_valid,
                    input wr_addr, input wr_data, input done_res, input last,
                    output ready);
endinterface

FILE: rtl/core/xcr_store.sv
// xcr_store: packet data memory, byte-lane writes, one registered word read a cycle
// depends on xcr_pkg
module xcr_store (
    input  logic                clk,
    input  xcr_pkg::store_req_t req,
    output logic [63:0]         rdata
);
    import xcr_pkg::*;

    logic [63:0] mem [NUM_WORDS];
    logic [63:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.widx][req.lane*8 +: 8] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.ridx];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/xcr_ctrl.sv
// xcr_ctrl: protocol state, checksum, word dump sequencer and result register
// depends on xcr_pkg, xcr_cmd_if, xcr_res_if; drives xcr_store
module xcr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         start_addr,
    input  logic [15:0]         timeout_ticks,
    xcr_cmd_if.sink             cmd,
    xcr_res_if.source           res,
    output xcr_pkg::store_req_t req,
    input  logic [63:0]         rdata
);
    import xcr_pkg::*;

    phase_t                phase_reg, phase_next;
    mode_t                 mode_reg, mode_next;
    logic [7:0]            cnt_reg, cnt_next;
    logic [7:0]            sum_reg, sum_next;
    logic [15:0]           ticks_reg, ticks_next;
    logic [31:0]           addr_reg, addr_next;
    logic [WORD_IDX_W-1:0] word_reg, word_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_reg, out_next;

    logic                  out_free;
    logic                  fire;
    logic [7:0]            cnt_inc;
    logic                  in_data;
    logic                  at_end;
    logic                  sum_ok;
    logic [16:0]           tick_inc;
    logic                  tick_over;
    logic [BYTE_IDX_W-1:0] byte_idx;
    logic [7:0]            sum_add;

    function automatic res_t mk_reply(input logic [7:0] code, input logic done);
        res_t r;
        r          = '0;
        r.tx_valid = 1'b1;
        r.tx_byte  = code;
        r.done_res = done;
        r.last     = 1'b1;
        return r;
    endfunction

    function automatic res_t mk_write(input logic [31:0] a, input logic [63:0] d);
        res_t r;
        r          = '0;
        r.wr_valid = 1'b1;
        r.wr_addr  = a;
        r.wr_data  = d;
        return r;
    endfunction

    assign out_free  = !out_valid_reg || res.ready;
    assign cmd.ready = (phase_reg == PH_RUN) && out_free;
    assign fire      = cmd.valid && cmd.ready;
    assign cnt_inc   = cnt_reg + 8'd1;
    assign in_data   = (cnt_inc >= 8'(FIRST_DATA)) && (cnt_inc < 8'(LAST_COUNT));
    assign at_end    = (cnt_inc == 8'(LAST_COUNT));
    assign sum_ok    = (sum_reg == cmd.rx_byte);
    assign tick_inc  = {1'b0, ticks_reg} + 17'd1;
    assign tick_over = tick_inc > {1'b0, timeout_ticks};
    assign byte_idx  = BYTE_IDX_W'(cnt_inc - 8'(FIRST_DATA));
    assign sum_add   = sum_reg + cmd.rx_byte;

    // sequencer next state
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_RUN:
            begin
                if (fire && cmd.func == FUNC_BYTE && mode_reg == MODE_PACKET
                    && at_end && sum_ok)
                begin
                    phase_next = PH_READ;
                end
            end
            PH_READ:
            begin
                phase_next = PH_WRITE;
            end
            PH_WRITE:
            begin
                if (out_free)
                begin
                    phase_next = (word_reg == WORD_IDX_W'(NUM_WORDS - 1)) ? PH_ACK : PH_READ;
                end
            end
            PH_ACK:
            begin
                if (out_free)
                begin
                    phase_next = PH_RUN;
                end
            end
            default:
            begin
                phase_next = PH_RUN;
            end
        endcase
    end

    // datapath, store access and result loading
    always_comb
    begin
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        ticks_next     = ticks_reg;
        addr_next      = addr_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_next       = out_reg;
        req            = '0;
        case (phase_reg)
            PH_RUN:
            begin
                if (fire)
                begin
                    case (cmd.func)
                        FUNC_START:
                        begin
                            addr_next  = start_addr;
                            ticks_next = '0;
                            cnt_next   = '0;
                            sum_next   = '0;
                            mode_next  = MODE_IDLE;
                        end
                        FUNC_TICK:
                        begin
                            if (mode_reg == MODE_IDLE)
                            begin
                                if (tick_over)
                                begin
                                    ticks_next     = '0;
                                    out_valid_next = 1'b1;
                                    out_next       = mk_reply(CH_NAK, 1'b0);
                                end
                                else
                                begin
                                    ticks_next = tick_inc[15:0];
                                end
                            end
                        end
                        FUNC_BYTE:
                        begin
                            case (mode_reg)
                                MODE_IDLE:
                                begin
                                    if (cmd.rx_byte == CH_SOH)
                                    begin
                                        cnt_next  = '0;
                                        sum_next  = '0;
                                        mode_next = MODE_PACKET;
                                    end
                                    else if (cmd.rx_byte == CH_EOT)
                                    begin
                                        mode_next      = MODE_STOPPED;
                                        out_valid_next = 1'b1;
                                        out_next       = mk_reply(CH_ACK, 1'b1);
                                    end
                                end
                                MODE_PACKET:
                                begin
                                    cnt_next = cnt_inc;
                                    if (in_data)
                                    begin
                                        req.we    = 1'b1;
                                        req.widx  = byte_idx[BYTE_IDX_W-1:LANE_W];
                                        req.lane  = byte_idx[LANE_W-1:0];
                                        req.wdata = cmd.rx_byte;
                                        sum_next  = sum_add;
                                    end
                                    else if (at_end)
                                    begin
                                        mode_next  = MODE_IDLE;
                                        ticks_next = '0;
                                        cnt_next   = '0;
                                        if (!sum_ok)
                                        begin
                                            out_valid_next = 1'b1;
                                            out_next       = mk_reply(CH_NAK, 1'b0);
                                        end
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            PH_READ:
            begin
                req.re   = 1'b1;
                req.ridx = word_reg;
            end
            PH_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = mk_write(addr_reg + 32'({word_reg, {LANE_W{1'b0}}}), rdata);
                    word_next      = word_reg + WORD_IDX_W'(1);
                end
            end
            PH_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = mk_reply(CH_ACK, 1'b0);
                    addr_next      = addr_reg + 32'(DATA_BYTES);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RUN;
            mode_reg      <= MODE_STOPPED;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            ticks_reg     <= '0;
            addr_reg      <= '0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            ticks_reg     <= ticks_next;
            addr_reg      <= addr_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res.valid    = out_valid_reg;
    assign res.tx_valid = out_reg.tx_valid;
    assign res.tx_byte  = out_reg.tx_byte;
    assign res.wr_valid = out_reg.wr_valid;
    assign res.wr_addr  = out_reg.wr_addr;
    assign res.wr_data  = out_reg.wr_data;
    assign res.done_res = out_reg.done_res;
    assign res.last     = out_reg.last;

    a_no_store_write_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_RUN |-> !req.we)
        else $error("store written during word dump");

    a_one_kind_per_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.wr_valid && out_reg.tx_valid))
        else $error("result carries both a reply and a write");

    a_addr_step_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ACK && out_free) |=> addr_reg == $past(addr_reg) + 32'(DATA_BYTES))
        else $error("write address not advanced by one block on ack");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_PACKET |-> cnt_reg < 8'(LAST_COUNT))
        else $error("packet byte count out of range");

    a_dump_starts_at_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RUN && phase_next == PH_READ) |-> word_reg == '0)
        else $error("word dump does not start at the first word");

endmodule

FILE: rtl/core/xmodem_checksum_receiver_unit.sv
// xmodem_checksum_receiver_unit: top level, configuration registers, controller and data memory
// depends on xcr_pkg, xcr_cmd_if, xcr_res_if, xcr_store, xcr_ctrl
//
//  channel  dir  handshake      payload
//  cmd      in   valid/ready    func[1:0], rx_byte[7:0]
//  res      out  valid/ready    tx_valid, tx_byte, wr_valid, wr_addr, wr_data, done_res, last
//  cfg      in   cfg_we only    cfg_index[0] (0 start address, 1 timeout_ticks), cfg_wdata[31:0]
//
// outside a dump, a start, tick or byte item is taken whenever the result register is free
// a good checksum starts a dump of 16 words: each word is read from memory, then loaded
// into the result register, and after the last word the ack is loaded; ready stays low
// until the ack is loaded and the next item is not taken before; the read-then-load word sequencer sets this
// a stalled result register holds the item input off and stretches the dump
// reset clears protocol state and loads start address 0 and timeout_ticks 1000;
// the data memory is not cleared, every entry is written in a packet before it is read
module xmodem_checksum_receiver_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    xcr_cmd_if.sink     cmd,
    xcr_res_if.source   res
);
    import xcr_pkg::*;

    // configuration registers
    logic [31:0] base_reg;
    logic [15:0] timeout_reg;

    // store request and read data between controller and memory
    store_req_t  req;
    logic [63:0] rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_ADDR:
                begin
                    base_reg <= cfg_wdata;
                end
                CFG_TIMEOUT_TICKS:
                begin
                    timeout_reg <= cfg_wdata[15:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // protocol control, checksum, dump sequencing and the result register
    xcr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start_addr    (base_reg),
        .timeout_ticks (timeout_reg),
        .cmd           (cmd),
        .res           (res),
        .req           (req),
        .rdata         (rdata)
    );

    // 128-byte packet buffer as 16 little-endian words
    xcr_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

endmodule

FILE: sim/xmodem_checksum_receiver_unit_tb.sv
// xmodem_checksum_receiver_unit_tb: self-checking bench for the xmodem checksum receiver
// drives item traffic and register writes, predicts every result and compares field by field
// depends on xcr_pkg, xcr_cmd_if, xcr_res_if and the xmodem_checksum_receiver_unit rtl
module xmodem_checksum_receiver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xcr_pkg::*;

    // func code that the block must ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // quiet cycles after the last result before the next register write
    localparam int SETTLE = 40;
    // length of the long result hold-off that backs the block up
    localparam int LONG_HOLD = 300;
    // items of short random traffic after the two packet phases
    localparam int RANDOM_ITEMS = 12;

    // one row of the opening stimulus table, reply typed in where it is obvious
    typedef struct {
        logic [1:0] func;
        logic [7:0] data;
        bit         has_reply;
        logic [7:0] reply;
        bit         done;
    } probe_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    xcr_cmd_if cmd_ch ();
    xcr_res_if res_ch ();

    xmodem_checksum_receiver_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // receiver state as the bench sees it
    // ------------------------------------------------------------------
    mode_t       rx_mode;
    logic [7:0]  rx_count;
    logic [7:0]  rx_sum;
    logic [15:0] idle_ticks;
    logic [31:0] next_wr_addr;
    logic [7:0]  pkt_bytes [DATA_BYTES];
    logic [31:0] base_addr_cfg;
    logic [15:0] timeout_cfg;

    // results of the item just accepted, then the ones still owed by the block
    res_t fresh_results [$];
    res_t due_results [$];

    int  items_sent;          // every accepted item
    int  err_count;
    bit  idling_on;
    int  hold_requests;       // bumped by the stimulus, served by the result side
    int  hold_served;

    function automatic res_t reply_item(input logic [7:0] code, input logic done);
        res_t r;
        r          = '0;
        r.tx_valid = 1'b1;
        r.tx_byte  = code;
        r.done_res = done;
        r.last     = 1'b1;
        return r;
    endfunction

    // advance the receiver by one accepted item and collect what it must emit
    task automatic absorb_item(input logic [1:0] f, input logic [7:0] b);
        logic [16:0] tick_next;
        res_t        word;
        fresh_results.delete();
        case (f)
            FUNC_START:
            begin
                // restart from the base address, any packet in flight is dropped
                next_wr_addr = base_addr_cfg;
                idle_ticks   = '0;
                rx_count     = '0;
                rx_sum       = '0;
                rx_mode      = MODE_IDLE;
            end
            FUNC_TICK:
            begin
                if (rx_mode == MODE_IDLE)
                begin
                    // one bit wider so a timeout of 65535 still fires
                    tick_next = {1'b0, idle_ticks} + 17'd1;
                    if (tick_next > {1'b0, timeout_cfg})
                    begin
                        idle_ticks = '0;
                        fresh_results.push_back(reply_item(CH_NAK, 1'b0));
                    end
                    else
                        idle_ticks = tick_next[15:0];
                end
            end
            FUNC_BYTE:
            begin
                if (rx_mode == MODE_IDLE)
                begin
                    if (b == CH_SOH)
                    begin
                        rx_count = '0;
                        rx_sum   = '0;
                        rx_mode  = MODE_PACKET;
                    end
                    else if (b == CH_EOT)
                    begin
                        rx_mode = MODE_STOPPED;
                        fresh_results.push_back(reply_item(CH_ACK, 1'b1));
                    end
                end
                else if (rx_mode == MODE_PACKET)
                begin
                    rx_count = rx_count + 8'd1;
                    if (rx_count >= FIRST_DATA && rx_count < LAST_COUNT)
                    begin
                        pkt_bytes[rx_count - FIRST_DATA] = b;
                        rx_sum = rx_sum + b;
                    end
                    else if (rx_count == LAST_COUNT)
                    begin
                        rx_mode    = MODE_IDLE;
                        idle_ticks = '0;
                        rx_count   = '0;
                        if (rx_sum != b)
                            fresh_results.push_back(reply_item(CH_NAK, 1'b0));
                        else
                        begin
                            // little-endian words at the running address, wrapping at 2^32
                            for (int k = 0; k < NUM_WORDS; k++)
                            begin
                                word          = '0;
                                word.wr_valid = 1'b1;
                                word.wr_addr  = next_wr_addr + 32'(k * WORD_BYTES);
                                for (int j = 0; j < WORD_BYTES; j++)
                                    word.wr_data[8*j +: 8] = pkt_bytes[k*WORD_BYTES + j];
                                fresh_results.push_back(word);
                            end
                            next_wr_addr = next_wr_addr + 32'(DATA_BYTES);
                            fresh_results.push_back(reply_item(CH_ACK, 1'b0));
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------

    // offer one item, optionally after a random gap; the expectation is pushed on acceptance
    task automatic send_item(input logic [1:0] f, input logic [7:0] b,
                             input bit typed = 1'b0, input res_t typed_res = '0,
                             input bit typed_reply = 1'b0);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 7);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.func    <= f;
        cmd_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        items_sent++;
        absorb_item(f, b);
        // table rows with a typed answer override the prediction
        if (typed)
        begin
            fresh_results.delete();
            if (typed_reply)
                fresh_results.push_back(typed_res);
        end
        foreach (fresh_results[i])
            due_results.push_back(fresh_results[i]);
    endtask

    // register write while the block has nothing in flight
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_START_ADDR:    base_addr_cfg = v;
            CFG_TIMEOUT_TICKS: timeout_cfg   = v[15:0];
            default: ;
        endcase
    endtask

    // stop offering items until every owed result is in, then let the dump logic settle
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // well-formed packet with random content; corrupt spoils the checksum,
    // squeeze asks for the long result hold-off just before the checksum byte
    task automatic send_packet(input bit corrupt, input bit squeeze);
        logic [7:0] blk;
        logic [7:0] sum;
        logic [7:0] d;
        int         style;
        blk   = 8'($urandom);
        style = $urandom_range(0, 7);
        sum   = '0;
        send_item(FUNC_BYTE, CH_SOH);
        // block number and its complement, not checked by the block
        send_item(FUNC_BYTE, blk);
        send_item(FUNC_BYTE, ~blk);
        for (int i = 0; i < DATA_BYTES; i++)
        begin
            // the odd tick or unused code inside a packet must change nothing
            if ($urandom_range(0, 39) == 0)
                send_item($urandom_range(0, 1) ? FUNC_TICK : FUNC_UNUSED, 8'($urandom));
            d = (style == 0) ? 8'hFF : (style == 1) ? 8'h00 : 8'($urandom);
            send_item(FUNC_BYTE, d);
            sum = sum + d;
        end
        if (corrupt)
            sum = sum + 8'($urandom_range(1, 255));
        if (squeeze)
            hold_requests++;
        send_item(FUNC_BYTE, sum);
    endtask

    // short random traffic: tick runs, noise and broken sequences, n items or a few more
    task automatic run_episodes(input int n_items);
        int items0;
        int n;
        items0 = items_sent;
        while (items_sent - items0 < n_items)
        begin
            case ($urandom_range(0, 4))
                0, 1:
                begin
                    // tick run, long enough to cross the timeout when it is small
                    n = (timeout_cfg < 4) ? $urandom_range(1, 3*timeout_cfg + 2)
                                          : $urandom_range(1, 6);
                    repeat (n) send_item(FUNC_TICK, 8'($urandom));
                end
                2:
                begin
                    // random noise, any func code and byte
                    n = $urandom_range(1, 4);
                    repeat (n) send_item(2'($urandom_range(0, 3)), 8'($urandom));
                end
                3:
                begin
                    // packet cut short, then a restart drops it
                    send_item(FUNC_BYTE, CH_SOH);
                    n = $urandom_range(0, 3);
                    repeat (n) send_item(FUNC_BYTE, 8'($urandom));
                    send_item(FUNC_START, 8'($urandom));
                end
                default:
                begin
                    // end of transfer, stray items while stopped, restart
                    send_item(FUNC_BYTE, CH_EOT);
                    n = $urandom_range(0, 2);
                    repeat (n) send_item(2'($urandom_range(0, 1)), 8'($urandom));
                    send_item(FUNC_START, 8'($urandom));
                end
            endcase
        end
    endtask

    // one register setting, a start and one full packet
    task automatic run_phase(input logic [31:0] base, input logic [31:0] tmo,
                             input bit squeeze, input bit corrupt);
        wait_drained();
        write_reg(CFG_START_ADDR, base);
        write_reg(CFG_TIMEOUT_TICKS, tmo);
        send_item(FUNC_START, 8'($urandom));
        send_packet(corrupt, squeeze);
        if (squeeze)
        begin
            // the sender keeps pushing during the hold-off, so the block backs up
            repeat (2) send_item(FUNC_TICK, 8'($urandom));
            // and then sits until everything is out
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // result side: ready with random stall bursts and the occasional long hold
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        hold_served  = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        // keep the log readable if everything goes wrong
        if (err_count <= 100)
            $display("%0t ns  %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // every accepted result against the oldest owed one
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (due_results.size() == 0)
                report_mismatch("result with nothing owed, wr_addr", 64'(res_ch.wr_addr), '0);
            else
            begin
                want = due_results.pop_front();
                if (res_ch.tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", 64'(res_ch.tx_valid), 64'(want.tx_valid));
                if (res_ch.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", 64'(res_ch.tx_byte), 64'(want.tx_byte));
                if (res_ch.wr_valid !== want.wr_valid)
                    report_mismatch("wr_valid", 64'(res_ch.wr_valid), 64'(want.wr_valid));
                if (res_ch.wr_addr !== want.wr_addr)
                    report_mismatch("wr_addr", 64'(res_ch.wr_addr), 64'(want.wr_addr));
                if (res_ch.wr_data !== want.wr_data)
                    report_mismatch("wr_data", res_ch.wr_data, want.wr_data);
                if (res_ch.done_res !== want.done_res)
                    report_mismatch("done_res", 64'(res_ch.done_res), 64'(want.done_res));
                if (res_ch.last !== want.last)
                    report_mismatch("last", 64'(res_ch.last), 64'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // opening table, run with timeout_ticks 1 so a nak comes on every second idle tick
    // ------------------------------------------------------------------
    probe_row_t probe_rows [24] = '{
        // stopped after reset: everything is ignored
        '{FUNC_BYTE,   CH_SOH, 1'b0, 8'h00,  1'b0},
        '{FUNC_BYTE,   CH_EOT, 1'b0, 8'h00,  1'b0},
        '{FUNC_TICK,   8'h00,  1'b0, 8'h00,  1'b0},
        '{FUNC_UNUSED, 8'hFF,  1'b0, 8'h00,  1'b0},
        // start, then the timeout fires on the second tick
        '{FUNC_START,  8'hFF,  1'b0, 8'h00,  1'b0},
        '{FUNC_TICK,   8'h00,  1'b0, 8'h00,  1'b0},
        '{FUNC_TICK,   8'hFF,  1'b1, CH_NAK, 1'b0},
        // other bytes and the unused code in idle
        '{FUNC_BYTE,   8'h00,  1'b0, 8'h00,  1'b0},
        '{FUNC_BYTE,   8'hFF,  1'b0, 8'h00,  1'b0},
        '{FUNC_UNUSED, 8'h00,  1'b0, 8'h00,  1'b0},
        '{FUNC_TICK,   8'h00,  1'b0, 8'h00,  1'b0},
        '{FUNC_TICK,   8'h00,  1'b1, CH_NAK, 1'b0},
        // packet opened, a tick inside it, then a restart drops it
        '{FUNC_BYTE,   CH_SOH, 1'b0, 8'h00,  1'b0},
        '{FUNC_BYTE,   8'h00,  1'b0, 8'h00,  1'b0},
        '{FUNC_TICK,   8'h00,  1'b0, 8'h00,  1'b0},
        '{FUNC_BYTE,   8'hFF,  1'b0, 8'h00,  1'b0},
        '{FUNC_BYTE,   8'hAA,  1'b0, 8'h00,  1'b0},
        '{FUNC_START,  8'h00,  1'b0, 8'h00,  1'b0},
        '{FUNC_TICK,   8'h00,  1'b0, 8'h00,  1'b0},
        '{FUNC_TICK,   8'h00,  1'b1, CH_NAK, 1'b0},
        // end of transfer acknowledged and flagged done
        '{FUNC_BYTE,   CH_EOT, 1'b1, CH_ACK, 1'b1},
        '{FUNC_TICK,   8'h00,  1'b0, 8'h00,  1'b0},
        '{FUNC_BYTE,   CH_SOH, 1'b0, 8'h00,  1'b0},
        '{FUNC_START,  8'h55,  1'b0, 8'h00,  1'b0}
    };

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = 1'b0;
        cfg_wdata      = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.func    = FUNC_BYTE;
        cmd_ch.rx_byte = '0;
        err_count      = 0;
        items_sent     = 0;
        hold_requests  = 0;
        idling_on      = 1'b0;

        // state after reset
        rx_mode       = MODE_STOPPED;
        rx_count      = '0;
        rx_sum        = '0;
        idle_ticks    = '0;
        next_wr_addr  = '0;
        base_addr_cfg = '0;
        timeout_cfg   = TIMEOUT_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_reg(CFG_TIMEOUT_TICKS, 32'd1);
        idling_on = 1'b1;
        foreach (probe_rows[i])
            send_item(probe_rows[i].func, probe_rows[i].data, 1'b1,
                      reply_item(probe_rows[i].reply, probe_rows[i].done),
                      probe_rows[i].has_reply);

        // good packet whose word addresses wrap, timeout 1, back-pressure test
        run_phase(32'hFFFF_FFC0, 32'd1, 1'b1, 1'b0);
        // bad checksum at a random base and a short random timeout
        run_phase($urandom, $urandom_range(1, 8), 1'b0, 1'b1);
        run_episodes(RANDOM_ITEMS);

        // largest timeout, no idling from here on
        wait_drained();
        idling_on = 1'b0;
        write_reg(CFG_START_ADDR, $urandom);
        write_reg(CFG_TIMEOUT_TICKS, 32'h0000_FFFF);
        send_item(FUNC_START, 8'($urandom));
        repeat (4) send_item(FUNC_TICK, 8'($urandom));
        send_item(FUNC_BYTE, CH_EOT);

        wait_drained();
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #8_000_000;
        $display("timeout with %0d results still owed", due_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
